// ===== rtl/text_encoding_detector_macros.svh =====
// ----------------------------------------------------------------------------
// text_encoding_detector_macros.svh
// Assertion macros shared by the encoding detector RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_ENCODING_DETECTOR_MACROS_SVH
`define TEXT_ENCODING_DETECTOR_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define TED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define TED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ted_pkg.sv =====
// ----------------------------------------------------------------------------
// ted_pkg
// Types shared by the text encoding detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ted_pkg;

  // Encoding codes as reported on the result channel
  typedef enum logic [3:0] {
    ENC_UTF8    = 4'd0,
    ENC_UTF16BE = 4'd1,
    ENC_UTF16LE = 4'd2,
    ENC_UTF32BE = 4'd3,
    ENC_UTF32LE = 4'd4,
    ENC_SCSU    = 4'd5,
    ENC_BOCU1   = 4'd6,
    ENC_WIN1252 = 4'd7,
    ENC_ASCII   = 4'd8
  } enc_e;

  // BOM match on the buffer so far, including the byte being accepted
  typedef struct packed {
    logic       found;
    enc_e       code;
    logic [2:0] len;
  } bom_res_t;

  // UTF-8 scan status, including the byte being accepted
  typedef struct packed {
    logic utf8_ok;   // valid and not ending inside a sequence
    logic high_seen; // some byte above 0x7F
  } utf8_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ted_bom_match.sv =====
// ----------------------------------------------------------------------------
// ted_bom_match
// Captures the first four bytes of a buffer and matches byte-order marks.
// ----------------------------------------------------------------------------
`default_nettype none

module ted_bom_match
  import ted_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic       last_i,
  input  wire logic [7:0] byte_i,
  output bom_res_t        bom_o
);

  localparam logic [7:0] ByteNul  = 8'h00;
  localparam logic [7:0] ByteEf   = 8'hef;
  localparam logic [7:0] ByteBb   = 8'hbb;
  localparam logic [7:0] ByteBf   = 8'hbf;
  localparam logic [7:0] ByteFe   = 8'hfe;
  localparam logic [7:0] ByteFf   = 8'hff;
  localparam logic [7:0] Byte0e   = 8'h0e;
  localparam logic [7:0] ByteFb   = 8'hfb;
  localparam logic [7:0] ByteEe   = 8'hee;
  localparam logic [7:0] Byte28   = 8'h28;

  logic [3:0][7:0] head_q, head_d;
  logic [2:0]      count_q, count_d;

  // Next head bytes and count; count saturates at four
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (!count_q[2]) begin
      head_d[count_q[1:0]] = byte_i;
      count_d              = count_q + 3'd1;
    end
  end

  // Head bytes: payload, qualified by the count
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else if (accept_i) begin
      count_q <= last_i ? 3'd0 : count_d;
    end
  end

  // Prefix match in table order; UTF-32LE ahead of UTF-16LE
  always_comb begin
    bom_o = '{found: 1'b0, code: ENC_ASCII, len: 3'd0};
    priority if (count_d >= 3'd3 && head_d[0] == ByteEf && head_d[1] == ByteBb &&
                 head_d[2] == ByteBf) begin
      bom_o = '{found: 1'b1, code: ENC_UTF8, len: 3'd3};
    end else if (count_d >= 3'd2 && head_d[0] == ByteFe && head_d[1] == ByteFf) begin
      bom_o = '{found: 1'b1, code: ENC_UTF16BE, len: 3'd2};
    end else if (count_d >= 3'd4 && head_d[0] == ByteFf && head_d[1] == ByteFe &&
                 head_d[2] == ByteNul && head_d[3] == ByteNul) begin
      bom_o = '{found: 1'b1, code: ENC_UTF32LE, len: 3'd4};
    end else if (count_d >= 3'd2 && head_d[0] == ByteFf && head_d[1] == ByteFe) begin
      bom_o = '{found: 1'b1, code: ENC_UTF16LE, len: 3'd2};
    end else if (count_d >= 3'd4 && head_d[0] == ByteNul && head_d[1] == ByteNul &&
                 head_d[2] == ByteFe && head_d[3] == ByteFf) begin
      bom_o = '{found: 1'b1, code: ENC_UTF32BE, len: 3'd4};
    end else if (count_d >= 3'd3 && head_d[0] == Byte0e && head_d[1] == ByteFe &&
                 head_d[2] == ByteFf) begin
      bom_o = '{found: 1'b1, code: ENC_SCSU, len: 3'd3};
    end else if (count_d >= 3'd3 && head_d[0] == ByteFb && head_d[1] == ByteEe &&
                 head_d[2] == Byte28) begin
      bom_o = '{found: 1'b1, code: ENC_BOCU1, len: 3'd3};
    end else begin
      bom_o = '{found: 1'b0, code: ENC_ASCII, len: 3'd0};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ted_utf8_check.sv =====
// ----------------------------------------------------------------------------
// ted_utf8_check
// Strict per-byte UTF-8 validation and high-byte tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module ted_utf8_check
  import ted_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic       last_i,
  input  wire logic [7:0] byte_i,
  output utf8_stat_t      stat_o
);

  localparam logic [7:0] ContLo  = 8'h80;
  localparam logic [7:0] ContHi  = 8'hbf;
  localparam logic [7:0] Lead2Lo = 8'hc2;
  localparam logic [7:0] Lead2Hi = 8'hdf;
  localparam logic [7:0] LeadE0  = 8'he0;
  localparam logic [7:0] LeadEd  = 8'hed;
  localparam logic [7:0] Lead3Hi = 8'hef;
  localparam logic [7:0] LeadF0  = 8'hf0;
  localparam logic [7:0] LeadF4  = 8'hf4;
  localparam logic [7:0] E0Lo    = 8'ha0;
  localparam logic [7:0] EdHi    = 8'h9f;
  localparam logic [7:0] F0Lo    = 8'h90;
  localparam logic [7:0] F4Hi    = 8'h8f;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] PrintLo = 8'h20;
  localparam logic [7:0] PrintHi = 8'h7e;

  logic [1:0] pend_q, pend_d;
  logic [7:0] lo_q, lo_d;
  logic [7:0] hi_q, hi_d;
  logic       valid_q, valid_d;
  logic       stop_q, stop_d;
  logic       high_q, high_d;

  // Next scan state for the incoming byte
  always_comb begin
    pend_d  = pend_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    valid_d = valid_q;
    stop_d  = stop_q;
    high_d  = high_q | byte_i[7];
    if (valid_q && !stop_q) begin
      if (pend_q != 2'd0) begin
        // continuation byte within the bounds set by its lead
        if (byte_i >= lo_q && byte_i <= hi_q) begin
          pend_d = pend_q - 2'd1;
          lo_d   = ContLo;
          hi_d   = ContHi;
        end else begin
          valid_d = 1'b0;
        end
      end else begin
        priority if (byte_i == ChNul) begin
          stop_d = 1'b1;
        end else if (byte_i == ChTab || byte_i == ChLf || byte_i == ChCr ||
                     (byte_i >= PrintLo && byte_i <= PrintHi)) begin
          pend_d = 2'd0;
        end else if (byte_i >= Lead2Lo && byte_i <= Lead2Hi) begin
          pend_d = 2'd1; lo_d = ContLo; hi_d = ContHi;
        end else if (byte_i == LeadE0) begin
          pend_d = 2'd2; lo_d = E0Lo;   hi_d = ContHi;
        end else if (byte_i == LeadEd) begin
          pend_d = 2'd2; lo_d = ContLo; hi_d = EdHi;
        end else if (byte_i > LeadE0 && byte_i <= Lead3Hi) begin
          pend_d = 2'd2; lo_d = ContLo; hi_d = ContHi;
        end else if (byte_i == LeadF0) begin
          pend_d = 2'd3; lo_d = F0Lo;   hi_d = ContHi;
        end else if (byte_i > LeadF0 && byte_i < LeadF4) begin
          pend_d = 2'd3; lo_d = ContLo; hi_d = ContHi;
        end else if (byte_i == LeadF4) begin
          pend_d = 2'd3; lo_d = ContLo; hi_d = F4Hi;
        end else begin
          valid_d = 1'b0;
        end
      end
    end
  end

  // Verdict as of this byte
  assign stat_o.utf8_ok   = valid_d && (stop_d || pend_d == 2'd0);
  assign stat_o.high_seen = high_d;

  // Scan state; the last byte of a buffer restarts it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 2'd0;
      lo_q    <= ContLo;
      hi_q    <= ContHi;
      valid_q <= 1'b1;
      stop_q  <= 1'b0;
      high_q  <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        pend_q  <= 2'd0;
        lo_q    <= ContLo;
        hi_q    <= ContHi;
        valid_q <= 1'b1;
        stop_q  <= 1'b0;
        high_q  <= 1'b0;
      end else begin
        pend_q  <= pend_d;
        lo_q    <= lo_d;
        hi_q    <= hi_d;
        valid_q <= valid_d;
        stop_q  <= stop_d;
        high_q  <= high_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_encoding_detector.sv =====
// ----------------------------------------------------------------------------
// text_encoding_detector
// Guesses the encoding of a byte buffer and reports its byte-order mark.
// ----------------------------------------------------------------------------
// Feed a buffer one byte per item with last_byte_i set on its final byte;
// one result (encoding code and BOM length) follows each final byte. The
// block takes one byte every clock cycle: per-byte scan state and the BOM
// head capture update per accepted byte, and the verdict for a final byte
// is registered at the edge that takes it and offered from the next cycle.
// A result taken in the cycle it is offered costs no input cycle; while a
// held result waits with out_ready_i low, input stalls until it is taken.
// Codes: 0 UTF-8, 1 UTF-16BE, 2 UTF-16LE, 3 UTF-32BE, 4 UTF-32LE, 5 SCSU,
// 6 BOCU-1, 7 Windows-1252, 8 ASCII.
`default_nettype none

`include "text_encoding_detector_macros.svh"

module text_encoding_detector
  import ted_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      encoding_o,
  output logic [2:0]      bom_length_o
);

  logic       accept;
  bom_res_t   bom;
  utf8_stat_t stat;
  enc_e       enc_d, enc_q;
  logic [2:0] len_d, len_q;
  logic       out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ted_bom_match u_bom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .last_i   (last_byte_i),
    .byte_i   (data_byte_i),
    .bom_o    (bom)
  );

  ted_utf8_check u_utf8 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .last_i   (last_byte_i),
    .byte_i   (data_byte_i),
    .stat_o   (stat)
  );

  // Verdict: BOM first, then UTF-8, then high-byte test
  always_comb begin
    len_d = 3'd0;
    priority if (bom.found) begin
      enc_d = bom.code;
      len_d = bom.len;
    end else if (stat.utf8_ok) begin
      enc_d = ENC_UTF8;
    end else if (stat.high_seen) begin
      enc_d = ENC_WIN1252;
    end else begin
      enc_d = ENC_ASCII;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      enc_q <= enc_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign encoding_o   = enc_q;
  assign bom_length_o = len_q;

  // Checks
  `TED_ASSERT_NEXT(a_last_gives_result, accept && last_byte_i, out_valid_o,
    "final item did not produce a result")
  `TED_ASSERT_NEXT(a_no_spurious_result, !out_valid_o && !(accept && last_byte_i),
    !out_valid_o, "result appeared without a final item")
  `TED_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o,
    "input stalled with empty output register")
  `TED_ASSERT_NOW(a_no_bom_codes, out_valid_o && bom_length_o == 3'd0,
    encoding_o == ENC_UTF8 || encoding_o == ENC_WIN1252 || encoding_o == ENC_ASCII,
    "BOM-only encoding reported without a BOM")

endmodule

`default_nettype wire
